/* rtl/core/kmmsc_pkg.sv */
// package with transaction types and constants of the keyed min/max/sum/count table
package kmmsc_pkg;

  localparam int KeyW       = 6;
  localparam int SampleW    = 8;
  localparam int SumW       = 40;
  localparam int CountW     = 32;
  localparam int KeysW      = 7;
  localparam int KeyLimit   = 1 << KeyW;

  localparam int NumKeysDefault    = 64;
  localparam int SampleBitsDefault = 8;

  localparam logic ActAdd   = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic                action;
    logic [KeyW-1:0]     key_index;
    logic [SampleW-1:0]  sample;
  } in_t;

  typedef struct packed {
    logic                entry_valid;
    logic [SampleW-1:0]  min_value;
    logic [SampleW-1:0]  max_value;
    logic [SumW-1:0]     sum_value;
    logic [CountW-1:0]   sample_count;
    logic [KeysW-1:0]    keys_in_use;
  } out_t;

endpackage

/* rtl/core/kmmsc_ram.sv */
// generic single-clock ram with one write port and one registered read port
module kmmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/kmmsc_agg.sv */
// aggregate update: new entry from stored entry and sample, with saturation
module kmmsc_agg #(
  parameter int SMP_W = 8
) (
  input  logic                      was_valid_i,
  input  logic [SMP_W-1:0]          sample_i,
  input  logic [SMP_W-1:0]          min_i,
  input  logic [SMP_W-1:0]          max_i,
  input  logic [kmmsc_pkg::SumW-1:0]   sum_i,
  input  logic [kmmsc_pkg::CountW-1:0] count_i,
  output logic [SMP_W-1:0]          min_o,
  output logic [SMP_W-1:0]          max_o,
  output logic [kmmsc_pkg::SumW-1:0]   sum_o,
  output logic [kmmsc_pkg::CountW-1:0] count_o
);

  logic [kmmsc_pkg::SumW:0] sum_ext;

  assign sum_ext = {1'b0, sum_i} + (kmmsc_pkg::SumW + 1)'(sample_i);

  always_comb begin
    if (!was_valid_i) begin
      min_o   = sample_i;
      max_o   = sample_i;
      sum_o   = kmmsc_pkg::SumW'(sample_i);
      count_o = kmmsc_pkg::CountW'(1);
    end else begin
      min_o   = (sample_i < min_i) ? sample_i : min_i;
      max_o   = (sample_i > max_i) ? sample_i : max_i;
      sum_o   = sum_ext[kmmsc_pkg::SumW] ? {kmmsc_pkg::SumW{1'b1}}
                                         : sum_ext[kmmsc_pkg::SumW-1:0];
      count_o = (&count_i) ? count_i : count_i + kmmsc_pkg::CountW'(1);
    end
  end

endmodule

/* rtl/core/keyed_min_max_sum_count_table.sv */
// top level of the keyed min/max/sum/count aggregation table
// Takes one transaction per clock cycle unless the output stalls, and returns one result per
// transaction through the stage-1 and output registers. An add transaction creates or
// updates the key's entry (min, max, saturating sum and count); a query reads it unchanged.
// The entries sit in one ram with a registered read: the entry is read when the transaction
// is accepted and written back when it leaves stage 1, and a write to the key that the
// following transaction reads is forwarded, so back-to-back updates of one key run at full
// rate. Valid bits and the keys-in-use count are flops cleared by reset, so no clearing pass
// is needed. Keys at or above NUM_KEYS and sample bits above SAMPLE_BITS are ignored.
module keyed_min_max_sum_count_table #(
  parameter int NUM_KEYS    = kmmsc_pkg::NumKeysDefault,
  parameter int SAMPLE_BITS = kmmsc_pkg::SampleBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kmmsc_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kmmsc_pkg::out_t   out_data_o
);

  localparam int Depth = (NUM_KEYS < kmmsc_pkg::KeyLimit) ? NUM_KEYS : kmmsc_pkg::KeyLimit;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int SmpW  = (SAMPLE_BITS < kmmsc_pkg::SampleW) ? SAMPLE_BITS
                                                            : kmmsc_pkg::SampleW;
  localparam int SumW  = kmmsc_pkg::SumW;
  localparam int CntFW = kmmsc_pkg::CountW;
  localparam int EntW  = 2 * SmpW + SumW + CntFW;

  logic              s1_v_q, s1_v_d;
  kmmsc_pkg::in_t    s1_q;
  logic              hit_q, hit_d;
  logic [EntW-1:0]   fwd_q;
  logic [Depth-1:0]  valid_q, valid_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_v_q, out_v_d;
  kmmsc_pkg::out_t   out_q, out_d;

  logic              in_fire, s1_fire;
  logic              s1_in, s1_add, was_valid, wr_en;
  logic [IdxW-1:0]   s1_idx;
  logic [EntW-1:0]   rdata, cur, nxt, res;
  logic [SmpW-1:0]   smp, cur_min, cur_max, nxt_min, nxt_max;
  logic [SumW-1:0]   cur_sum, nxt_sum;
  logic [CntFW-1:0]  cur_cnt, nxt_cnt;

  assign s1_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_in     = 32'(s1_q.key_index) < NUM_KEYS;
  assign s1_idx    = s1_q.key_index[IdxW-1:0];
  assign s1_add    = s1_in && (s1_q.action == kmmsc_pkg::ActAdd);
  assign was_valid = s1_in && valid_q[s1_idx];
  assign wr_en     = s1_fire && s1_add;
  assign smp       = s1_q.sample[SmpW-1:0];

  assign cur = hit_q ? fwd_q : rdata;
  assign {cur_min, cur_max, cur_sum, cur_cnt} = cur;
  assign nxt = {nxt_min, nxt_max, nxt_sum, nxt_cnt};
  assign res = s1_add ? nxt : cur;

  kmmsc_ram #(
    .WIDTH (EntW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (nxt),
    .re_i    (in_fire),
    .raddr_i (in_data_i.key_index[IdxW-1:0]),
    .rdata_o (rdata)
  );

  kmmsc_agg #(
    .SMP_W (SmpW)
  ) u_agg (
    .was_valid_i (was_valid),
    .sample_i    (smp),
    .min_i       (cur_min),
    .max_i       (cur_max),
    .sum_i       (cur_sum),
    .count_i     (cur_cnt),
    .min_o       (nxt_min),
    .max_o       (nxt_max),
    .sum_o       (nxt_sum),
    .count_o     (nxt_cnt)
  );

  always_comb begin
    s1_v_d  = s1_v_q;
    hit_d   = hit_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    out_v_d = out_v_q;
    out_d   = out_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (s1_fire) begin
      s1_v_d = 1'b0;
      out_v_d = 1'b1;
      if (s1_add && !was_valid) begin
        valid_d[s1_idx] = 1'b1;
        cnt_d = cnt_q + CntW'(1);
      end
      out_d.entry_valid  = s1_add || was_valid;
      out_d.min_value    = '0;
      out_d.max_value    = '0;
      out_d.sum_value    = '0;
      out_d.sample_count = '0;
      if (s1_add || was_valid) begin
        out_d.min_value    = kmmsc_pkg::SampleW'(res[EntW-1 -: SmpW]);
        out_d.max_value    = kmmsc_pkg::SampleW'(res[EntW-SmpW-1 -: SmpW]);
        out_d.sum_value    = res[SumW+CntFW-1 -: SumW];
        out_d.sample_count = res[CntFW-1:0];
      end
      out_d.keys_in_use = kmmsc_pkg::KeysW'(cnt_d);
    end
    if (in_fire) begin
      s1_v_d = 1'b1;
      hit_d  = wr_en && (s1_q.key_index == in_data_i.key_index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      hit_q   <= 1'b0;
      valid_q <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      hit_q   <= hit_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (wr_en) begin
      fwd_q <= nxt;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
